### sv/shpd_pkg.sv
// ============================================================================
// shpd_pkg
// Shared types, constants and helpers for the strip hit packet decoder.
// ============================================================================
package shpd_pkg;

    localparam int CHANNELS    = 32;
    localparam int COUNT_W     = 10;
    localparam int COUNT_MAX   = 1023;
    localparam int QUEUE_DEPTH = 2;
    localparam int CHAN_W      = $clog2(CHANNELS);

    typedef enum logic [1:0] {
        PH_START         = 2'd0,
        PH_START_NOCHECK = 2'd1,
        PH_DATA          = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHANNELS-1:0] hits;
        logic [6:0]          chip;
        logic [7:0]          unit;
        logic [15:0]         hit_time;
        logic [14:0]         evt_id;
        logic                rf_state;
        logic                summ;
        logic [COUNT_W-1:0]  recs;
        logic [COUNT_W-1:0]  hdrs;
        logic                trunc;
    } entry_t;

    // Output order index k maps to channel {~k[4:3], k[2:0]}.
    function automatic logic [CHAN_W-1:0] channel_of(input logic [CHAN_W-1:0] k);
        channel_of = {~k[4:3], k[2:0]};
    endfunction

    function automatic logic [CHANNELS-1:0] order_mask(input logic [CHANNELS-1:0] hits);
        logic [CHANNELS-1:0] om;
        om = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            om[k] = hits[channel_of(CHAN_W'(k))];
        end
        order_mask = om;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        if (v >= COUNT_W'(COUNT_MAX))
        begin
            sat_inc = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            sat_inc = v + COUNT_W'(1);
        end
    endfunction

endpackage

### sv/shpd_front.sv
// ============================================================================
// shpd_front
// Parses packet words, tracks record state and pushes one entry per word.
// ============================================================================
module shpd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [31:0]    in_word,
    input  logic           in_last,
    output logic           push_valid,
    input  logic           push_ready,
    output shpd_pkg::entry_t push_entry
);
    import shpd_pkg::*;

    phase_t             phase_reg, phase_next;
    logic               at_start_reg, at_start_next;
    logic [6:0]         chip_reg, chip_next;
    logic [7:0]         unit_reg, unit_next;
    logic [15:0]        time_reg, time_next;
    logic [14:0]        event_reg, event_next;
    logic               rf_reg, rf_next;
    logic [COUNT_W-1:0] recs_reg, recs_next;
    logic [COUNT_W-1:0] hdrs_reg, hdrs_next;
    logic               accept;

    assign in_ready   = push_ready;
    assign push_valid = in_valid;
    assign accept     = in_valid && push_ready;

    always_comb
    begin
        phase_next    = phase_reg;
        at_start_next = at_start_reg;
        chip_next     = chip_reg;
        unit_next     = unit_reg;
        time_next     = time_reg;
        event_next    = event_reg;
        rf_next       = rf_reg;
        recs_next     = recs_reg;
        hdrs_next     = hdrs_reg;
        push_entry    = '0;

        if (at_start_reg)
        begin
            event_next = in_word[14:0];
            rf_next    = in_word[15];
        end
        at_start_next = 1'b0;

        push_entry.chip     = chip_reg;
        push_entry.unit     = unit_reg;
        push_entry.hit_time = time_reg;

        unique case (phase_reg)
            PH_DATA:
            begin
                push_entry.hits = order_mask(~in_word);
                phase_next      = PH_START;
            end
            PH_START_NOCHECK:
            begin
                chip_next  = in_word[30:24];
                unit_next  = in_word[23:16];
                time_next  = in_word[15:0];
                recs_next  = sat_inc(recs_reg);
                phase_next = PH_DATA;
            end
            default:
            begin
                if (!in_word[31])
                begin
                    hdrs_next  = sat_inc(hdrs_reg);
                    phase_next = PH_START_NOCHECK;
                end
                else
                begin
                    chip_next  = in_word[30:24];
                    unit_next  = in_word[23:16];
                    time_next  = in_word[15:0];
                    recs_next  = sat_inc(recs_reg);
                    phase_next = PH_DATA;
                end
            end
        endcase

        push_entry.evt_id   = event_next;
        push_entry.rf_state = rf_next;
        push_entry.recs     = recs_next;
        push_entry.hdrs     = hdrs_next;
        push_entry.summ     = in_last;
        push_entry.trunc    = (phase_next != PH_START);

        if (in_last)
        begin
            phase_next    = PH_START;
            at_start_next = 1'b1;
            chip_next     = '0;
            unit_next     = '0;
            time_next     = '0;
            recs_next     = '0;
            hdrs_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            at_start_reg <= 1'b1;
            chip_reg     <= '0;
            unit_reg     <= '0;
            time_reg     <= '0;
            event_reg    <= '0;
            rf_reg       <= 1'b0;
            recs_reg     <= '0;
            hdrs_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            at_start_reg <= at_start_next;
            chip_reg     <= chip_next;
            unit_reg     <= unit_next;
            time_reg     <= time_next;
            event_reg    <= event_next;
            rf_reg       <= rf_next;
            recs_reg     <= recs_next;
            hdrs_reg     <= hdrs_next;
        end
    end

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> at_start_reg && phase_reg == PH_START && recs_reg == '0)
        else $error("packet end did not restore the start state");

endmodule

### sv/shpd_queue.sv
// ============================================================================
// shpd_queue
// Short entry queue between the word parser and the hit serializer.
// ============================================================================
module shpd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  shpd_pkg::entry_t push_entry,
    output logic           pop_valid,
    input  logic           pop_ready,
    output shpd_pkg::entry_t pop_entry
);
    import shpd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_entry  = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds its depth");

endmodule

### sv/shpd_back.sv
// ============================================================================
// shpd_back
// Serializes queued entries into hit results and event summaries.
// ============================================================================
module shpd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  shpd_pkg::entry_t pop_entry,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           out_kind,
    output logic           out_last,
    output logic [6:0]     out_chip,
    output logic [7:0]     out_unit,
    output logic [4:0]     out_channel,
    output logic [15:0]    out_time,
    output logic [14:0]    out_event,
    output logic           out_rf,
    output logic [9:0]     out_recs,
    output logic [9:0]     out_hdrs,
    output logic           out_trunc
);
    import shpd_pkg::*;

    entry_t              work_reg, work_next;
    logic                wv_reg, wv_next;
    logic                ov_reg, ov_next;
    logic                kind_reg, kind_next;
    logic                last_reg, last_next;
    logic [6:0]          chip_reg, chip_next;
    logic [7:0]          unit_reg, unit_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [15:0]         time_reg, time_next;
    logic [14:0]         event_reg, event_next;
    logic                rf_reg, rf_next;
    logic [COUNT_W-1:0]  recs_reg, recs_next;
    logic [COUNT_W-1:0]  hdrs_reg, hdrs_next;
    logic                trunc_reg, trunc_next;

    logic                emit_ok, has_item, fire, final_one, work_done, load;
    logic                mask_zero, mask_single;
    logic [CHANNELS-1:0] low_bit;
    logic [CHAN_W-1:0]   low_idx;

    always_comb
    begin
        low_idx = '0;
        for (int k = CHANNELS - 1; k >= 0; k--)
        begin
            if (work_reg.hits[k])
            begin
                low_idx = CHAN_W'(k);
            end
        end
    end

    assign low_bit     = work_reg.hits & (~work_reg.hits + CHANNELS'(1));
    assign mask_zero   = (work_reg.hits == '0);
    assign mask_single = ((work_reg.hits & (work_reg.hits - CHANNELS'(1))) == '0);
    assign emit_ok     = !ov_reg || out_ready;
    assign has_item    = wv_reg && (!mask_zero || work_reg.summ);
    assign fire        = has_item && emit_ok;
    assign final_one   = mask_zero || (mask_single && !work_reg.summ);
    assign work_done   = !has_item || (fire && final_one);
    assign load        = work_done && pop_valid;
    assign pop_ready   = work_done;

    always_comb
    begin
        work_next  = work_reg;
        wv_next    = wv_reg;
        ov_next    = ov_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        chip_next  = chip_reg;
        unit_next  = unit_reg;
        chan_next  = chan_reg;
        time_next  = time_reg;
        event_next = event_reg;
        rf_next    = rf_reg;
        recs_next  = recs_reg;
        hdrs_next  = hdrs_reg;
        trunc_next = trunc_reg;

        if (fire)
        begin
            work_next.hits = work_reg.hits & ~low_bit;
            if (mask_zero)
            begin
                work_next.summ = 1'b0;
            end
        end

        if (load)
        begin
            work_next = pop_entry;
            wv_next   = 1'b1;
        end
        else if (work_done)
        begin
            wv_next = 1'b0;
        end

        if (emit_ok)
        begin
            ov_next = fire;
        end

        if (fire)
        begin
            kind_next  = mask_zero;
            last_next  = final_one;
            event_next = work_reg.evt_id;
            rf_next    = work_reg.rf_state;
            if (mask_zero)
            begin
                chip_next  = '0;
                unit_next  = '0;
                chan_next  = '0;
                time_next  = '0;
                recs_next  = work_reg.recs;
                hdrs_next  = work_reg.hdrs;
                trunc_next = work_reg.trunc;
            end
            else
            begin
                chip_next  = work_reg.chip;
                unit_next  = work_reg.unit;
                chan_next  = channel_of(low_idx);
                time_next  = work_reg.hit_time;
                recs_next  = '0;
                hdrs_next  = '0;
                trunc_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        chip_reg  <= chip_next;
        unit_reg  <= unit_next;
        chan_reg  <= chan_next;
        time_reg  <= time_next;
        event_reg <= event_next;
        rf_reg    <= rf_next;
        recs_reg  <= recs_next;
        hdrs_reg  <= hdrs_next;
        trunc_reg <= trunc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= wv_next;
            ov_reg <= ov_next;
        end
    end

    assign out_valid   = ov_reg;
    assign out_kind    = kind_reg;
    assign out_last    = last_reg;
    assign out_chip    = chip_reg;
    assign out_unit    = unit_reg;
    assign out_channel = chan_reg;
    assign out_time    = time_reg;
    assign out_event   = event_reg;
    assign out_rf      = rf_reg;
    assign out_recs    = recs_reg;
    assign out_hdrs    = hdrs_reg;
    assign out_trunc   = trunc_reg;

    a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && kind_reg |-> last_reg)
        else $error("summary request is not the final one of its word");

    a_hit_no_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !kind_reg |-> recs_reg == '0 && hdrs_reg == '0 && !trunc_reg)
        else $error("hit request carries summary fields");

    a_load_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !has_item || (fire && final_one))
        else $error("entry loaded while results remain");

endmodule

### sv/strip_hit_packet_decoder.sv
// ============================================================================
// strip_hit_packet_decoder
// Decodes readout packet words into per-channel hit requests and a summary.
// ============================================================================
// Entries pass the queue, the serializer's work register and the output registers.
// Throughput: one word per cycle while each word yields at most one result and
// the output is ready; a data word whose cleared bits (and summary) give more holds
// the serializer until each is emitted, and the two-entry queue then back-pressures the input.
// Reset: asynchronous; clears the parser to packet start and empties the queue.
module strip_hit_packet_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // word[31:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // chip[6:0], unit[14:7], channel[19:15],
                                   // hit_time[35:20], event_id[50:36],
                                   // rf_state[51], record_count[61:52],
                                   // header_count[71:62], truncated[72], zeros
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast
);
    import shpd_pkg::*;

    entry_t      push_entry, pop_entry;
    logic        push_valid, push_ready, pop_valid, pop_ready;
    logic [6:0]  o_chip;
    logic [7:0]  o_unit;
    logic [4:0]  o_channel;
    logic [15:0] o_time;
    logic [14:0] o_event;
    logic        o_rf;
    logic [9:0]  o_recs;
    logic [9:0]  o_hdrs;
    logic        o_trunc;

    shpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    shpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    shpd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_entry   (pop_entry),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_last    (m_tlast),
        .out_chip    (o_chip),
        .out_unit    (o_unit),
        .out_channel (o_channel),
        .out_time    (o_time),
        .out_event   (o_event),
        .out_rf      (o_rf),
        .out_recs    (o_recs),
        .out_hdrs    (o_hdrs),
        .out_trunc   (o_trunc)
    );

    assign m_tdata = {7'd0, o_trunc, o_hdrs, o_recs, o_rf, o_event, o_time,
                      o_channel, o_unit, o_chip};

endmodule

### dv/tb.sv
// ============================================================================
// tb
// Self-checking testbench for the strip hit packet decoder. Words go in as
// packets under bursty valid, results come out under a changing ready
// pattern, and every hit and summary is checked field by field against a
// cycle-free decoder kept in the bench.
// ============================================================================
module tb;
    import shpd_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 11;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          RANDOM_WORDS = 450;
    localparam int          MAX_PRINTED  = 200;
    localparam logic        KIND_HIT     = 1'b0;
    localparam logic        KIND_SUMMARY = 1'b1;
    localparam logic [31:0] NO_HITS      = 32'hFFFF_FFFF;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_QUARTER,
        READY_PATTERN
    } stall_mode_t;

    typedef struct packed {
        logic               kind;
        logic [6:0]         chip;
        logic [7:0]         unit;
        logic [4:0]         channel;
        logic [15:0]        hit_time;
        logic [14:0]        evt_id;
        logic               rf_state;
        logic [COUNT_W-1:0] record_count;
        logic [COUNT_W-1:0] header_count;
        logic               truncated;
        logic               last_result;
    } hit_report_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    phase_t             parse_phase;
    logic               at_start;
    logic [6:0]         cur_chip;
    logic [7:0]         cur_unit;
    logic [15:0]        cur_time;
    logic [14:0]        cur_event;
    logic               cur_rf;
    logic [COUNT_W-1:0] rec_cnt;
    logic [COUNT_W-1:0] hdr_cnt;

    hit_report_t reports_due[$];

    int unsigned error_count;
    int unsigned words_sent;
    int unsigned packets_sent;
    int unsigned hits_checked;
    int unsigned summaries_checked;
    int unsigned truncated_checked;
    int          burst_left;
    int          cycles;

    strip_hit_packet_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic clear_packet_state();
        parse_phase = PH_START;
        at_start    = 1'b1;
        cur_chip    = '0;
        cur_unit    = '0;
        cur_time    = '0;
        rec_cnt     = '0;
        hdr_cnt     = '0;
    endtask

    task automatic decode_word(input logic [31:0] w, input logic lst);
        hit_report_t r;
        int          pushed;
        int          c;
        pushed = 0;
        if (at_start)
        begin
            cur_event = w[14:0];
            cur_rf    = w[15];
            at_start  = 1'b0;
        end
        if (parse_phase == PH_DATA)
        begin
            for (int b = 3; b >= 0; b--)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    c = b * 8 + i;
                    if (!w[c])
                    begin
                        r          = '0;
                        r.kind     = KIND_HIT;
                        r.chip     = cur_chip;
                        r.unit     = cur_unit;
                        r.channel  = c[4:0];
                        r.hit_time = cur_time;
                        r.evt_id   = cur_event;
                        r.rf_state = cur_rf;
                        reports_due.insert(reports_due.size(), r);
                        pushed++;
                    end
                end
            end
            parse_phase = PH_START;
        end
        else if (parse_phase != PH_START_NOCHECK && !w[31])
        begin
            if (hdr_cnt < COUNT_MAX)
            begin
                hdr_cnt++;
            end
            parse_phase = PH_START_NOCHECK;
        end
        else
        begin
            cur_chip = w[30:24];
            cur_unit = w[23:16];
            cur_time = w[15:0];
            if (rec_cnt < COUNT_MAX)
            begin
                rec_cnt++;
            end
            parse_phase = PH_DATA;
        end
        if (lst)
        begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.evt_id       = cur_event;
            r.rf_state     = cur_rf;
            r.record_count = rec_cnt;
            r.header_count = hdr_cnt;
            r.truncated    = (parse_phase != PH_START);
            reports_due.insert(reports_due.size(), r);
            pushed++;
            clear_packet_state();
        end
        if (pushed > 0)
        begin
            reports_due[reports_due.size() - 1].last_result = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (error_count < MAX_PRINTED)
        begin
            $display("mismatch in %s at cycle %0d: got 0x%0h, wanted 0x%0h",
                     what, cycles, got, want);
        end
        error_count++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        decode_word(w, lst);
        burst_left--;
        words_sent++;
        if (lst)
        begin
            packets_sent++;
        end
    endtask

    function automatic logic [31:0] shaped_word();
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            return w;
        end
        case (parse_phase)
            PH_DATA:
            begin
                if (pick < 30)
                begin
                    w = NO_HITS;
                end
                else if (pick < 60)
                begin
                    w = NO_HITS & ~(32'd1 << $urandom_range(0, 31))
                                & ~(32'd1 << $urandom_range(0, 31));
                end
                else if (pick < 85)
                begin
                    w = w | $urandom | $urandom;
                end
                else if (pick >= 95)
                begin
                    w = 32'h0000_0000;
                end
            end
            PH_START_NOCHECK:
            begin
            end
            default:
            begin
                w[31] = (pick >= 40);
            end
        endcase
        return w;
    endfunction

    task automatic test_lone_words();
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h7FFF_7FFF, 1'b1);
        send_word(32'h8000_8000, 1'b1);
    endtask

    task automatic test_hit_order();
        send_word(32'hFFAB_1234, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8A5C_F00F, 1'b0);
        send_word(NO_HITS, 1'b0);
        send_word(32'hFF00_0000, 1'b0);
        send_word(32'h7FFF_FFFE, 1'b1);
    endtask

    task automatic test_header_skip();
        send_word(32'h0012_3456, 1'b0);
        send_word(32'h0055_AAAA, 1'b0);
        send_word(32'hFEFF_FF7F, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8001_0002, 1'b0);
        send_word(32'h5555_AAAA, 1'b1);
        send_word(32'h8123_4567, 1'b0);
        send_word(32'hEFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        send_word(32'h0BAD_F00D, 1'b0);
        send_word(32'h1234_5678, 1'b1);
        send_word(32'hC0DE_0001, 1'b1);
    endtask

    task automatic test_random_packets();
        int plen;
        int sent;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
            for (int k = 0; k < plen; k++)
            begin
                send_word(shaped_word(), k == plen - 1);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        hit_report_t got;
        hit_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind         = m_tuser;
            got.chip         = m_tdata[6:0];
            got.unit         = m_tdata[14:7];
            got.channel      = m_tdata[19:15];
            got.hit_time     = m_tdata[35:20];
            got.evt_id       = m_tdata[50:36];
            got.rf_state     = m_tdata[51];
            got.record_count = m_tdata[61:52];
            got.header_count = m_tdata[71:62];
            got.truncated    = m_tdata[72];
            got.last_result  = m_tlast;
            if (reports_due.size() == 0)
            begin
                report_mismatch("result with nothing due", 64'(got), 0);
            end
            else
            begin
                want = reports_due.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", got.kind, want.kind);
                if (got.chip != want.chip)
                    report_mismatch("chip", got.chip, want.chip);
                if (got.unit != want.unit)
                    report_mismatch("unit", got.unit, want.unit);
                if (got.channel != want.channel)
                    report_mismatch("channel", got.channel, want.channel);
                if (got.hit_time != want.hit_time)
                    report_mismatch("hit_time", got.hit_time, want.hit_time);
                if (got.evt_id != want.evt_id)
                    report_mismatch("event id", got.evt_id, want.evt_id);
                if (got.rf_state != want.rf_state)
                    report_mismatch("rf_state", got.rf_state, want.rf_state);
                if (got.record_count != want.record_count)
                    report_mismatch("record_count", got.record_count, want.record_count);
                if (got.header_count != want.header_count)
                    report_mismatch("header_count", got.header_count, want.header_count);
                if (got.truncated != want.truncated)
                    report_mismatch("truncated", got.truncated, want.truncated);
                if (got.last_result != want.last_result)
                    report_mismatch("last_result", got.last_result, want.last_result);
                if (want.kind == KIND_HIT)
                begin
                    hits_checked++;
                end
                else
                begin
                    summaries_checked++;
                    if (want.truncated)
                    begin
                        truncated_checked++;
                    end
                end
            end
            if (m_tdata[79:73] != '0)
            begin
                report_mismatch("tdata padding", m_tdata[79:73], 0);
            end
        end
    end

    initial
    begin
        stall_mode_t mode;
        int          hold;
        int          tick;
        logic [7:0]  pattern;
        m_tready = 1'b0;
        hold     = 0;
        tick     = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                mode    = stall_mode_t'($urandom_range(0, 3));
                hold    = $urandom_range(20, 150);
                pattern = 8'($urandom);
            end
            hold--;
            tick++;
            case (mode)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_COIN:    m_tready <= 1'($urandom_range(0, 1));
                READY_QUARTER: m_tready <= (tick % 4 == 0);
                default:       m_tready <= pattern[tick % 8];
            endcase
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results still due",
                 cycles, reports_due.size());
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        cur_event   = '0;
        cur_rf      = 1'b0;
        burst_left  = 0;
        error_count = 0;
        clear_packet_state();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_lone_words();
        test_hit_order();
        test_header_skip();
        test_random_packets();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d words in %0d packets, directed and randomly shaped",
                 words_sent, packets_sent);
        $display("checked %0d hits and %0d summaries, %0d of them truncated, with %0d errors",
                 hits_checked, summaries_checked, truncated_checked, error_count);
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### strip_hit_packet_decoder.f
sv/shpd_pkg.sv
sv/shpd_front.sv
sv/shpd_queue.sv
sv/shpd_back.sv
sv/strip_hit_packet_decoder.sv
dv/tb.sv
